### rtl/csfg_pkg.sv
// csfg_pkg: shared types and constants for the counting semaphore block
// result codes, field widths, controller/datapath command and status structs
// no dependencies
package csfg_pkg;

	// fixed field widths
	localparam int REQ_ID_W     = 8;
	localparam int COUNT_W      = 16;
	localparam int WAITERS_W    = 5;
	localparam int CFG_ADDR_W   = 3;
	localparam int CFG_DATA_W   = 32;

	localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 16'd1;

	// request kinds
	localparam logic REQ_WAIT   = 1'b0;
	localparam logic REQ_SIGNAL = 1'b1;

	// register word index, taken from paddr[2]
	localparam logic REG_INITIAL_COUNT = 1'b0;

	typedef enum logic [2:0] {
		RC_GRANTED     = 3'd0,
		RC_QUEUED      = 3'd1,
		RC_INCREMENTED = 3'd2,
		RC_HANDED      = 3'd3,
		RC_FULL        = 3'd4,
		RC_SATURATED   = 3'd5
	} result_code_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic exec;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
	} dp_status_t;

	// configuration write toward the datapath
	typedef struct packed {
		logic               we;
		logic [COUNT_W-1:0] value;
	} cfg_wr_t;

endpackage

### rtl/csfg_if.sv
// csfg_in_if / csfg_out_if: valid/ready channels for requests and results
// depends on csfg_pkg
interface csfg_in_if;
	logic                          valid;
	logic                          ready;
	logic                          req_type;
	logic [csfg_pkg::REQ_ID_W-1:0] requester_id;

	modport source (output valid, req_type, requester_id, input ready);
	modport sink   (input valid, req_type, requester_id, output ready);
endinterface

interface csfg_out_if;
	logic                           valid;
	logic                           ready;
	csfg_pkg::result_code_t         result_code;
	logic [csfg_pkg::REQ_ID_W-1:0]  granted_id;
	logic [csfg_pkg::COUNT_W-1:0]   count_now;
	logic [csfg_pkg::WAITERS_W-1:0] waiters_now;

	modport source (output valid, result_code, granted_id, count_now, waiters_now,
		input ready);
	modport sink   (input valid, result_code, granted_id, count_now, waiters_now,
		output ready);
endinterface

### rtl/csfg_ram.sv
// csfg_ram: generic single-port-write, single-port-read RAM with registered read
// no dependencies
module csfg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/csfg_ctrl.sv
// csfg_ctrl: two-state sequencer, accept an item then execute it
// depends on csfg_pkg
module csfg_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  csfg_pkg::dp_status_t  status,
	output csfg_pkg::ctrl_cmd_t   cmd
);
	import csfg_pkg::*;

	state_t state_q;
	state_t state_next;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_next = ST_EXEC;
			end
			ST_EXEC: begin
				if (status.out_free) state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.exec    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_EXEC: begin
				cmd.exec = status.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

### rtl/csfg_dp.sv
// csfg_dp: permit count, wait queue pointers, queue RAM and result register
// depends on csfg_pkg and csfg_ram
module csfg_dp #(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_WIDTH    = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  csfg_pkg::ctrl_cmd_t                cmd,
	output csfg_pkg::dp_status_t               status,
	input  csfg_pkg::cfg_wr_t                  cfg,
	input  logic                               req_type,
	input  logic [csfg_pkg::REQ_ID_W-1:0]      requester_id,
	output logic                               out_valid,
	input  logic                               out_ready,
	output csfg_pkg::result_code_t             result_code,
	output logic [csfg_pkg::REQ_ID_W-1:0]      granted_id,
	output logic [csfg_pkg::COUNT_W-1:0]       count_now,
	output logic [csfg_pkg::WAITERS_W-1:0]     waiters_now
);
	import csfg_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int TOT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [TOT_W-1:0] TOT_FULL = TOT_W'(QUEUE_DEPTH);

	logic [COUNT_W-1:0]  count_q;
	logic [PTR_W-1:0]    head_q;
	logic [PTR_W-1:0]    tail_q;
	logic [TOT_W-1:0]    total_q;
	logic                req_type_q;
	logic [ID_WIDTH-1:0] id_q;
	logic [ID_WIDTH-1:0] head_id;

	logic                out_valid_q;
	result_code_t        code_q;
	logic [REQ_ID_W-1:0] gid_q;
	logic [COUNT_W-1:0]  cnt_out_q;
	logic [WAITERS_W-1:0] wait_out_q;

	logic [COUNT_W-1:0]  count_nx;
	logic [PTR_W-1:0]    head_nx;
	logic [PTR_W-1:0]    tail_nx;
	logic [TOT_W-1:0]    total_nx;
	result_code_t        code_nx;
	logic [ID_WIDTH-1:0] gid_nx;
	logic                push;

	// waiter id store, read at the head when an item is captured
	csfg_ram #(
		.WIDTH(ID_WIDTH),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk  (clk),
		.we   (push),
		.waddr(tail_q),
		.wdata(id_q),
		.re   (cmd.capture),
		.raddr(head_q),
		.rdata(head_id)
	);

	// capture the request
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_type_q <= req_type;
			id_q       <= ID_WIDTH'(requester_id);
		end
	end

	// semaphore step
	always_comb begin
		count_nx = count_q;
		head_nx  = head_q;
		tail_nx  = tail_q;
		total_nx = total_q;
		gid_nx   = '0;
		push     = 1'b0;
		code_nx  = RC_FULL;
		if (req_type_q == REQ_WAIT) begin
			if (count_q != '0) begin
				count_nx = count_q - 1'b1;
				gid_nx   = id_q;
				code_nx  = RC_GRANTED;
			end else if (total_q != TOT_FULL) begin
				push     = cmd.exec;
				tail_nx  = (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;
				total_nx = total_q + 1'b1;
				code_nx  = RC_QUEUED;
			end
		end else begin
			if (total_q != '0) begin
				gid_nx   = head_id;
				head_nx  = (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
				total_nx = total_q - 1'b1;
				code_nx  = RC_HANDED;
			end else if (count_q == COUNT_MAX) begin
				code_nx = RC_SATURATED;
			end else begin
				count_nx = count_q + 1'b1;
				code_nx  = RC_INCREMENTED;
			end
		end
	end

	// semaphore state, loaded by a configuration write, else updated on exec
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_RESET;
			head_q  <= '0;
			tail_q  <= '0;
			total_q <= '0;
		end else if (cfg.we) begin
			count_q <= cfg.value;
			head_q  <= '0;
			tail_q  <= '0;
			total_q <= '0;
		end else if (cmd.exec) begin
			count_q <= count_nx;
			head_q  <= head_nx;
			tail_q  <= tail_nx;
			total_q <= total_nx;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			code_q     <= code_nx;
			gid_q      <= REQ_ID_W'(gid_nx);
			cnt_out_q  <= count_nx;
			wait_out_q <= WAITERS_W'(total_nx);
		end
	end

	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign result_code     = code_q;
	assign granted_id      = gid_q;
	assign count_now       = cnt_out_q;
	assign waiters_now     = wait_out_q;

endmodule

### rtl/counting_semaphore_fifo_grant_top.sv
// counting_semaphore_fifo_grant_top: counting semaphore with a FIFO wait queue
// depends on csfg_pkg, csfg_if, csfg_ctrl, csfg_dp, csfg_ram
//
//   port   dir   kind     carries
//   req    in    vld/rdy  req_type, requester_id
//   rsp    out   vld/rdy  result_code, granted_id, count_now, waiters_now
//   p*     in    apb      initial_count at byte address 0
//
// each item is first captured, with the queue head read from the
// queue RAM; the execute step then updates the count and pointers and loads the result register.
// the result register holds while rsp is stalled; the next item is taken meanwhile
// and executes once the result register is free.
// reset: count 1, queue empty; writing initial_count reloads the count and
// empties the queue.
module counting_semaphore_fifo_grant_top #(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_WIDTH    = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	csfg_in_if.sink                             req,
	csfg_out_if.source                          rsp,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [csfg_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [csfg_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic [csfg_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                                pready
);
	import csfg_pkg::*;

	ctrl_cmd_t          cmd;
	dp_status_t         status;
	cfg_wr_t            cfg;
	logic [COUNT_W-1:0] init_count_q;

	// register decode
	assign pready    = 1'b1;
	assign cfg.we    = psel && penable && pwrite && pready && (paddr[2] == REG_INITIAL_COUNT);
	assign cfg.value = pwdata[COUNT_W-1:0];

	// initial_count readback copy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_count_q <= COUNT_RESET;
		end else if (cfg.we) begin
			init_count_q <= cfg.value;
		end
	end

	assign prdata = (paddr[2] == REG_INITIAL_COUNT) ? CFG_DATA_W'(init_count_q) : '0;

	csfg_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(req.valid),
		.in_ready(req.ready),
		.status  (status),
		.cmd     (cmd)
	);

	csfg_dp #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.ID_WIDTH   (ID_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.cfg         (cfg),
		.req_type    (req.req_type),
		.requester_id(req.requester_id),
		.out_valid   (rsp.valid),
		.out_ready   (rsp.ready),
		.result_code (rsp.result_code),
		.granted_id  (rsp.granted_id),
		.count_now   (rsp.count_now),
		.waiters_now (rsp.waiters_now)
	);

	// one item in flight: no back-to-back accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("item accepted while previous item still executing");

	// a grant consumed a permit, so the count cannot sit at its maximum
	a_grant_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.result_code == RC_GRANTED) |-> rsp.count_now != COUNT_MAX)
		else $error("grant reported with saturated count");

	// queueing or rejecting a wait only happens with no permits left
	a_queue_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.result_code == RC_QUEUED || rsp.result_code == RC_FULL)
		|-> rsp.count_now == '0)
		else $error("wait queued or rejected while permits remain");

endmodule
